// ===== hdl/affine_composite_segment_tree_defines.svh =====
// ----------------------------------------------------------------------------
// affine composite segment tree: assertion macros
// Shared assertion macros, clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef AFFINE_COMPOSITE_SEGMENT_TREE_DEFINES_SVH
`define AFFINE_COMPOSITE_SEGMENT_TREE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ACST_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ACST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ACST_ASSERT_NOW(lbl, ante, cons)
`define ACST_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/acst_pkg.sv =====
// ----------------------------------------------------------------------------
// acst_pkg
// Word width, node layout and codes shared by the affine composite tree.
// ----------------------------------------------------------------------------
package acst_pkg;

    // all arithmetic wraps at this width
    localparam int WIDTH     = 32;
    localparam int MUL_LANES = 4;

    typedef logic [WIDTH-1:0] word_t;

    // one tree node: f(x) = mul * x + add
    typedef struct packed {
        word_t mul;
        word_t add;
    } node_t;

    localparam word_t WORD_ONE  = word_t'(1);
    localparam word_t WORD_ZERO = '0;

    localparam logic MODE_SET   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

endpackage

// ===== hdl/affine_composite_segment_tree.sv =====
// ----------------------------------------------------------------------------
// affine_composite_segment_tree
// Point-set / range-composite segment tree over affine functions mod 2^32.
//
//   channel   dir  tdata                                    tuser / meaning
//   s_axis    in   left_or_pos, right_end, coef_mul,        mode (0 set, 1 query)
//                  coef_add, arg_x                          
//   m_axis    out  value                                    one item per query
//
// A set writes its leaf and then walks up to the root; a query walks both
// range ends up at most log2(LEAVES) + 1 levels, then combines the two sides
// and applies them to arg_x before its value goes out on m_axis. Every tree
// level costs a read of the node memory, a multiply and a write or accumulate.
// After reset the node memory is swept to identity, one entry a cycle, over
// all 2*LEAVES nodes, during which no item is taken. Items are taken only while
// the sequencer is idle; a query result that waits on m_axis_tready holds the
// sequencer in its last state, while a result already in the output register
// does not block the next item.
// ----------------------------------------------------------------------------
`include "affine_composite_segment_tree_defines.svh"

module affine_composite_segment_tree
    import acst_pkg::*;
#(
    parameter int LEAVES = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [9:0] left_or_pos, [19:10] right_end, [51:20] coef_mul,
    // [83:52] coef_add, [115:84] arg_x, [119:116] zero
    input  logic [119:0] s_axis_tdata,
    // [0] mode
    input  logic         s_axis_tuser,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] value
    output logic [31:0]  m_axis_tdata
);

    localparam int NODES = 2 * LEAVES;
    localparam int NW    = (NODES > 1) ? $clog2(NODES) : 1;

    localparam logic [NW-1:0] LAST_NODE  = NW'(NODES - 1);
    localparam logic [31:0]   LEAVES32   = 32'(LEAVES);
    localparam logic [31:0]   LAST_LEAF  = 32'(LEAVES - 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SRD   = 4'd2;
    localparam logic [3:0] S_SMUL  = 4'd3;
    localparam logic [3:0] S_SWR   = 4'd4;
    localparam logic [3:0] S_QRD   = 4'd5;
    localparam logic [3:0] S_QMUL  = 4'd6;
    localparam logic [3:0] S_QUPD  = 4'd7;
    localparam logic [3:0] S_F1    = 4'd8;
    localparam logic [3:0] S_F2    = 4'd9;
    localparam logic [3:0] S_F3    = 4'd10;

    // input unpacking
    logic        in_mode;
    logic [31:0] in_lpos;
    logic [31:0] in_rpos;
    word_t       in_cmul;
    word_t       in_cadd;
    word_t       in_argx;

    assign in_mode = s_axis_tuser;
    assign in_lpos = {22'b0, s_axis_tdata[9:0]};
    assign in_rpos = {22'b0, s_axis_tdata[19:10]};
    assign in_cmul = word_t'(s_axis_tdata[51:20]);
    assign in_cadd = word_t'(s_axis_tdata[83:52]);
    assign in_argx = word_t'(s_axis_tdata[115:84]);

    logic          leaf_ok;
    logic [NW-1:0] leaf_addr;
    logic [31:0]   rpos_sat;
    logic          range_empty;
    logic [NW-1:0] right_addr;

    assign leaf_ok     = in_lpos < LEAVES32;
    assign leaf_addr   = NW'(in_lpos + LEAVES32);
    assign rpos_sat    = (in_rpos > LAST_LEAF) ? LAST_LEAF : in_rpos;
    assign range_empty = in_lpos > rpos_sat;
    assign right_addr  = NW'(rpos_sat + LEAVES32);

    // control and payload registers
    logic [3:0]    state_reg, state_next;
    logic [NW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [NW-1:0] v_reg, v_next;
    logic [NW-1:0] l_reg, l_next;
    logic [NW-1:0] r_reg, r_next;
    word_t         la_reg, la_next;
    word_t         lb_reg, lb_next;
    word_t         ra_reg, ra_next;
    word_t         rb_reg, rb_next;
    word_t         x_reg, x_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [31:0]   m_tdata_reg, m_tdata_next;

    // node memory
    node_t         node_ram [NODES];
    node_t         rd0_reg;
    node_t         rd1_reg;
    logic          ram_we;
    logic [NW-1:0] ram_waddr;
    node_t         ram_wdata;
    logic          ram_re;
    logic [NW-1:0] ram_raddr0;
    logic [NW-1:0] ram_raddr1;

    // multiplier bank
    logic  mul_en;
    word_t op_a [MUL_LANES];
    word_t op_b [MUL_LANES];
    word_t prod [MUL_LANES];

    acst_mul_bank u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    logic [NW:0]   l_inc;
    logic [NW-1:0] l_step;
    logic [NW-1:0] r_step;
    logic [NW-1:0] v_up;

    assign l_inc  = {1'b0, l_reg} + {{NW{1'b0}}, 1'b1};
    assign l_step = l_inc[NW:1];
    assign r_step = (r_reg - NW'(1)) >> 1;
    assign v_up   = v_reg >> 1;

    // children of v for set walks, l and r for queries
    assign ram_raddr0 = (state_reg == S_QRD) ? l_reg : NW'(v_reg << 1);
    assign ram_raddr1 = (state_reg == S_QRD) ? r_reg : (NW'(v_reg << 1) | NW'(1));

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        v_next        = v_reg;
        l_next        = l_reg;
        r_next        = r_reg;
        la_next       = la_reg;
        lb_next       = lb_reg;
        ra_next       = ra_reg;
        rb_next       = rb_reg;
        x_next        = x_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = v_reg;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        mul_en        = 1'b0;
        for (int i = 0; i < MUL_LANES; i++) begin
            op_a[i] = '0;
            op_b[i] = '0;
        end

        if (m_tvalid_reg && m_axis_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '{mul: WORD_ONE, add: WORD_ZERO};
                clr_cnt_next = clr_cnt_reg + NW'(1);
                if (clr_cnt_reg == LAST_NODE) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (in_mode == MODE_SET) begin
                        // out-of-tree positions are dropped
                        if (leaf_ok) begin
                            ram_we    = 1'b1;
                            ram_waddr = leaf_addr;
                            ram_wdata = '{mul: in_cmul, add: in_cadd};
                            v_next    = leaf_addr >> 1;
                            if ((leaf_addr >> 1) != '0) begin
                                state_next = S_SRD;
                            end
                        end
                    end else begin
                        x_next  = in_argx;
                        la_next = WORD_ONE;
                        lb_next = WORD_ZERO;
                        ra_next = WORD_ONE;
                        rb_next = WORD_ZERO;
                        l_next  = leaf_addr;
                        r_next  = right_addr;
                        state_next = range_empty ? S_F1 : S_QRD;
                    end
                end
            end
            S_SRD: begin
                ram_re     = 1'b1;
                state_next = S_SMUL;
            end
            S_SMUL: begin
                mul_en     = 1'b1;
                op_a[0]    = rd0_reg.mul;
                op_b[0]    = rd1_reg.mul;
                op_a[1]    = rd1_reg.mul;
                op_b[1]    = rd0_reg.add;
                state_next = S_SWR;
            end
            S_SWR: begin
                // parent = right child after left child
                ram_we     = 1'b1;
                ram_waddr  = v_reg;
                ram_wdata  = '{mul: prod[0], add: rd1_reg.add + prod[1]};
                v_next     = v_up;
                state_next = (v_up == '0) ? S_IDLE : S_SRD;
            end
            S_QRD: begin
                ram_re     = 1'b1;
                state_next = S_QMUL;
            end
            S_QMUL: begin
                mul_en     = 1'b1;
                op_a[0]    = la_reg;
                op_b[0]    = rd0_reg.mul;
                op_a[1]    = rd0_reg.mul;
                op_b[1]    = lb_reg;
                op_a[2]    = ra_reg;
                op_b[2]    = rd1_reg.add;
                op_a[3]    = ra_reg;
                op_b[3]    = rd1_reg.mul;
                state_next = S_QUPD;
            end
            S_QUPD: begin
                if (l_reg[0]) begin
                    la_next = prod[0];
                    lb_next = rd0_reg.add + prod[1];
                end
                if (!r_reg[0]) begin
                    rb_next = rb_reg + prod[2];
                    ra_next = prod[3];
                end
                l_next     = l_step;
                r_next     = r_step;
                state_next = (l_step <= r_step) ? S_QRD : S_F1;
            end
            S_F1: begin
                mul_en     = 1'b1;
                op_a[0]    = la_reg;
                op_b[0]    = ra_reg;
                op_a[1]    = ra_reg;
                op_b[1]    = lb_reg;
                state_next = S_F2;
            end
            S_F2: begin
                // combined function applied to x
                mul_en     = 1'b1;
                op_a[0]    = prod[0];
                op_b[0]    = x_reg;
                lb_next    = rb_reg + prod[1];
                state_next = S_F3;
            end
            S_F3: begin
                if (!m_tvalid_reg || m_axis_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = 32'(prod[0] + lb_reg);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg       <= v_next;
        l_reg       <= l_next;
        r_reg       <= r_next;
        la_reg      <= la_next;
        lb_reg      <= lb_next;
        ra_reg      <= ra_next;
        rb_reg      <= rb_next;
        x_reg       <= x_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            node_ram[ram_waddr] <= ram_wdata;
        end
        if (ram_re) begin
            rd0_reg <= node_ram[ram_raddr0];
            rd1_reg <= node_ram[ram_raddr1];
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    `ACST_ASSERT_NOW(a_qrd_range, state_reg == S_QRD, (l_reg <= r_reg) && (l_reg != '0))
    `ACST_ASSERT_NOW(a_swr_node, state_reg == S_SWR, v_reg != '0)
    `ACST_ASSERT_NOW(a_valid_src, $rose(m_tvalid_reg), $past(state_reg) == S_F3)
    `ACST_ASSERT_NEXT(a_f3_hold, (state_reg == S_F3) && m_tvalid_reg && !m_axis_tready, state_reg == S_F3)

endmodule

// ===== hdl/acst_mul_bank.sv =====
// ----------------------------------------------------------------------------
// acst_mul_bank
// Four registered multipliers, each keeping the low word of its product.
// ----------------------------------------------------------------------------
module acst_mul_bank
    import acst_pkg::*;
(
    input  logic  aclk,
    input  logic  en,
    input  word_t op_a [MUL_LANES],
    input  word_t op_b [MUL_LANES],
    output word_t prod [MUL_LANES]
);

    word_t prod_reg [MUL_LANES];

    for (genvar i = 0; i < MUL_LANES; i++) begin : g_lane
        logic [2*WIDTH-1:0] full;

        assign full = {{WIDTH{1'b0}}, op_a[i]} * {{WIDTH{1'b0}}, op_b[i]};

        // products hold while disabled so later states can still use them
        always_ff @(posedge aclk) begin
            if (en) begin
                prod_reg[i] <= full[WIDTH-1:0];
            end
        end

        assign prod[i] = prod_reg[i];
    end

endmodule
